// ----- rtl/core/kte_pkg.sv -----
// Package for the keyboard typeahead engine: sizes, operation codes, the
// control-word type with its program ROM, and the keymap reset contents.
// No dependencies; used by kte_keymap and keyboard_typeahead_engine_core.
package kte_pkg;

  localparam int KEYS      = 3;               // key codes per report
  localparam int SLOT_W    = $clog2(KEYS);
  localparam int CNT_W     = $clog2(KEYS + 1);
  localparam int CODE_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int MAP_DEPTH = 256;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Ring depth must stay a power of two: the pointers wrap by overflow.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int EDIT_KEY_FIRST = 128;
  localparam int EDIT_KEY_LAST  = 135;

  localparam logic [CHAR_W-1:0] CHAR_CTRL_C  = 8'h03;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_FIRST   = 8'h01;
  localparam logic [CHAR_W-1:0] CHAR_LAST    = 8'h7E;
  localparam logic [CHAR_W-1:0] ESCAPE_RESET = 8'd27;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_ESCAPE_ADDR = 3'd0;

  typedef enum logic [1:0] {
    OP_REPORT    = 2'd0,
    OP_BREAK     = 2'd1,
    OP_MAP_WRITE = 2'd2,
    OP_POP       = 2'd3
  } op_t;

  // Program addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_RD0       = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RD1_EV0   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RD2_EV1   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_EV2_DONE  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MAP_WR    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_POP_RD    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_POP_TAKE  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_POP_EMPTY = 3'd7;

  typedef struct packed {
    logic              rd_en;      // keymap lookup for rd_slot
    logic [SLOT_W-1:0] rd_slot;
    logic              ev_en;      // judge ev_slot with last lookup
    logic [SLOT_W-1:0] ev_slot;
    logic              commit;     // update previous codes, latest code
    logic              map_wr;     // keymap entry write
    logic              pop_rd;     // ring read at head
    logic              jmp_empty;  // branch to jmp_to when ring empty
    logic [STEP_W-1:0] jmp_to;
    logic              pop_take;   // advance head, result holds char
    logic              emit;       // load result, end of program
  } ctrl_t;

  // Keymap port request
  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
  } km_req_t;

  function automatic logic [STEP_W-1:0] entry_step(op_t op);
    logic [STEP_W-1:0] s;
    case (op)
      OP_REPORT:    s = STEP_RD0;
      OP_BREAK:     s = STEP_RD0;
      OP_MAP_WRITE: s = STEP_MAP_WR;
      OP_POP:       s = STEP_POP_RD;
      default:      s = STEP_RD0;
    endcase
    return s;
  endfunction

  function automatic ctrl_t prog_rom(logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      STEP_RD0: begin
        c.rd_en = 1'b1; c.rd_slot = SLOT_W'(0);
      end
      STEP_RD1_EV0: begin
        c.rd_en = 1'b1; c.rd_slot = SLOT_W'(1);
        c.ev_en = 1'b1; c.ev_slot = SLOT_W'(0);
      end
      STEP_RD2_EV1: begin
        c.rd_en = 1'b1; c.rd_slot = SLOT_W'(2);
        c.ev_en = 1'b1; c.ev_slot = SLOT_W'(1);
      end
      STEP_EV2_DONE: begin
        c.ev_en = 1'b1; c.ev_slot = SLOT_W'(2);
        c.commit = 1'b1; c.emit = 1'b1;
      end
      STEP_MAP_WR: begin
        c.map_wr = 1'b1; c.emit = 1'b1;
      end
      STEP_POP_RD: begin
        c.pop_rd = 1'b1; c.jmp_empty = 1'b1; c.jmp_to = STEP_POP_EMPTY;
      end
      STEP_POP_TAKE: begin
        c.pop_take = 1'b1; c.emit = 1'b1;
      end
      STEP_POP_EMPTY: begin
        c.emit = 1'b1;
      end
      default: begin
        c.emit = 1'b1;
      end
    endcase
    return c;
  endfunction

  // Keymap contents after reset
  function automatic logic [CHAR_W-1:0] map_reset_value(logic [MAP_AW-1:0] idx);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (idx == CHAR_CR || idx == CHAR_LF) begin
      v = CHAR_LF;
    end else if (idx >= CHAR_FIRST && idx <= CHAR_LAST) begin
      v = idx;
    end else if (int'(idx) >= EDIT_KEY_FIRST && int'(idx) <= EDIT_KEY_LAST) begin
      v = idx;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/keyboard_typeahead_engine_core.sv -----
// Keyboard typeahead engine, top level: request capture, microcoded
// sequencer, typeahead ring, result register and APB register.
// Depends on kte_pkg and kte_keymap.
//
// Takes one request at a time on the s_axis side and returns exactly one
// result on m_axis. A report request (normal or break-check) carries three
// 16-bit key codes; nonzero codes not present in the previous report are
// translated through the keymap and queued in a 64-slot ring (63 usable),
// or flag a break in break-check mode when they are escape or ctrl-C.
// Other requests write a keymap entry or pop one queued character.
// Sequence: the keymap's single read port sets a report's program (one
// lookup per step: three lookup steps, the second and third also judging
// the previous key, then a final judge step that loads the result); a
// keymap write loads its result in its only step, and a pop first reads
// the ring (the read is registered), then loads the result. The next
// request is accepted in the cycle after the result is loaded, even if
// that result has not been taken yet. The program only stalls on its
// last step while the result register is still full. No clearing pass
// after reset: keymap entries carry valid bits and read their reset
// translation until written.
// The escape character lives at APB address 0 (reset 27).
module keyboard_typeahead_engine_core (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] key_code_a, [31:16] key_code_b, [47:32] key_code_c,
  // [55:48] map_index, [63:56] map_value
  input  logic [63:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] pressed_count, [17:2] last_raw_code, [18] break_hit,
  // [26:19] popped_char, [27] char_valid, [31:28] zero
  output logic [31:0] m_axis_tdata,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kte_pkg::APB_AW-1:0]   paddr,
  input  logic [kte_pkg::APB_DW-1:0]   pwdata,
  output logic [kte_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [kte_pkg::CHAR_W-1:0] escape_code;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == kte_pkg::REG_ESCAPE_ADDR);
  assign prdata = (paddr == kte_pkg::REG_ESCAPE_ADDR)
                  ? kte_pkg::APB_DW'(escape_code) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code <= kte_pkg::ESCAPE_RESET;
    end else if (cfg_wr) begin
      escape_code <= pwdata[kte_pkg::CHAR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Request capture and sequencer
  // ---------------------------------------------------------------------
  logic                          busy;
  logic [kte_pkg::STEP_W-1:0]    step;
  kte_pkg::op_t                  op;
  logic [kte_pkg::CODE_W-1:0]    key_r [kte_pkg::KEYS];
  logic [kte_pkg::MAP_AW-1:0]    map_index;
  logic [kte_pkg::CHAR_W-1:0]    map_value;
  kte_pkg::ctrl_t                ctrl;
  logic                          in_acc;
  logic                          out_free;
  logic                          go;
  logic                          brk;

  assign s_axis_tready = !busy && !rst;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign ctrl     = kte_pkg::prog_rom(step);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  // the emitting step waits for a free result register; nothing else stalls
  assign go       = busy && (!ctrl.emit || out_free);
  assign brk      = (op == kte_pkg::OP_BREAK);

  // ---------------------------------------------------------------------
  // Keymap
  // ---------------------------------------------------------------------
  kte_pkg::km_req_t            km_req;
  logic [kte_pkg::CHAR_W-1:0]  km_rd;

  assign km_req.rd_en   = go && ctrl.rd_en;
  assign km_req.rd_addr = key_r[ctrl.rd_slot][kte_pkg::MAP_AW-1:0];
  assign km_req.wr_en   = go && ctrl.map_wr;
  assign km_req.wr_addr = map_index;
  assign km_req.wr_data = map_value;

  kte_keymap u_keymap (
    .clk     (clk),
    .rst     (rst),
    .req     (km_req),
    .rd_data (km_rd)
  );

  // ---------------------------------------------------------------------
  // Judge one key: freshness against previous report, translation
  // ---------------------------------------------------------------------
  logic [kte_pkg::CODE_W-1:0]  prev [kte_pkg::KEYS];
  logic [kte_pkg::CODE_W-1:0]  ev_code;
  logic [kte_pkg::CHAR_W-1:0]  ev_char;
  logic                        ev_fresh;
  logic                        ev_act;
  logic                        ev_hit;
  logic                        push_req;

  assign ev_code = key_r[ctrl.ev_slot];
  // codes of 256 and up have no keymap entry
  assign ev_char = (|ev_code[kte_pkg::CODE_W-1:kte_pkg::MAP_AW]) ? '0 : km_rd;

  always_comb begin
    ev_fresh = 1'b1;
    for (int j = 0; j < kte_pkg::KEYS; j++) begin
      if (prev[j] == ev_code) begin
        ev_fresh = 1'b0;
      end
    end
  end

  assign ev_act   = go && ctrl.ev_en && (ev_code != '0) && ev_fresh && (ev_char != '0);
  assign ev_hit   = ev_act && brk
                    && (ev_char == escape_code || ev_char == kte_pkg::CHAR_CTRL_C);
  assign push_req = ev_act && !ev_hit;

  // ---------------------------------------------------------------------
  // Report summary: compacted codes, count, latest raw code
  // ---------------------------------------------------------------------
  logic [kte_pkg::CODE_W-1:0]  comp [kte_pkg::KEYS];
  logic [kte_pkg::CNT_W-1:0]   cnt;
  logic [kte_pkg::CODE_W-1:0]  latest;
  logic [kte_pkg::CODE_W-1:0]  latest_next;

  always_comb begin
    cnt         = '0;
    latest_next = latest;
    for (int i = 0; i < kte_pkg::KEYS; i++) begin
      comp[i] = '0;
    end
    for (int i = 0; i < kte_pkg::KEYS; i++) begin
      if (key_r[i] != '0) begin
        comp[cnt[kte_pkg::SLOT_W-1:0]] = key_r[i];
        cnt = cnt + 1'b1;
        if (!brk) begin
          latest_next = key_r[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Typeahead ring (contents undefined until written)
  // ---------------------------------------------------------------------
  logic [kte_pkg::CHAR_W-1:0]  ring [kte_pkg::RING_DEPTH];
  logic [kte_pkg::RING_AW-1:0] head;
  logic [kte_pkg::RING_AW-1:0] tail;
  logic [kte_pkg::RING_AW-1:0] tail_inc;
  logic [kte_pkg::CHAR_W-1:0]  ring_rd;
  logic                        push_ok;
  logic                        ring_empty;
  logic                        pop_fire;

  assign tail_inc   = tail + 1'b1;
  assign push_ok    = push_req && (tail_inc != head);  // full ring drops
  assign ring_empty = (head == tail);
  assign pop_fire   = go && ctrl.pop_take;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ring[tail] <= ev_char;
    end
    if (go && ctrl.pop_rd) begin
      ring_rd <= ring[head];
    end
  end

  // ---------------------------------------------------------------------
  // Control state, architectural state and result register
  // ---------------------------------------------------------------------
  logic                        hit;
  logic [31:0]                 result;

  assign result = {4'b0,
                   ctrl.pop_take,
                   ctrl.pop_take ? ring_rd : {kte_pkg::CHAR_W{1'b0}},
                   hit || ev_hit,
                   ctrl.commit ? latest_next : latest,
                   ctrl.commit ? cnt : {kte_pkg::CNT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r[0]  <= s_axis_tdata[15:0];
      key_r[1]  <= s_axis_tdata[31:16];
      key_r[2]  <= s_axis_tdata[47:32];
      map_index <= s_axis_tdata[55:48];
      map_value <= s_axis_tdata[63:56];
      op        <= kte_pkg::op_t'(s_axis_tuser);
    end
    if (go && ctrl.emit) begin
      m_axis_tdata <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      step          <= '0;
      hit           <= 1'b0;
      head          <= '0;
      tail          <= '0;
      latest        <= '0;
      m_axis_tvalid <= 1'b0;
      for (int j = 0; j < kte_pkg::KEYS; j++) begin
        prev[j] <= '0;
      end
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
        step <= kte_pkg::entry_step(kte_pkg::op_t'(s_axis_tuser));
        hit  <= 1'b0;
      end else if (go) begin
        if (ctrl.emit) begin
          busy <= 1'b0;
        end else if (ctrl.jmp_empty && ring_empty) begin
          step <= ctrl.jmp_to;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (ev_hit) begin
        hit <= 1'b1;
      end
      if (push_ok) begin
        tail <= tail_inc;
      end
      if (pop_fire) begin
        head <= head + 1'b1;
      end
      if (go && ctrl.commit) begin
        latest <= latest_next;
        for (int j = 0; j < kte_pkg::KEYS; j++) begin
          prev[j] <= comp[j];
        end
      end
      if (go && ctrl.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // an accepted request always starts the program
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> busy)
    else $error("request accepted but sequencer idle");

  // only nonzero characters are queued, so a popped character is nonzero
  a_pop_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[27]) |-> (m_axis_tdata[26:19] != '0))
    else $error("queued character reads as zero");

  // a break needs at least one key in the report
  a_break_has_key: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[1:0] != '0))
    else $error("break flagged on an empty report");

  // head moves only on the pop step of the program
  a_head_on_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && head != $past(head)) |-> $past(pop_fire))
    else $error("ring head moved outside a pop");
`endif

endmodule

// ----- rtl/core/kte_keymap.sv -----
// Writable 256-entry keymap with registered read and per-entry valid bits;
// an entry never written reads as its reset translation.
// Depends on kte_pkg.
module kte_keymap (
  input  logic                          clk,
  input  logic                          rst,
  input  kte_pkg::km_req_t              req,
  output logic [kte_pkg::CHAR_W-1:0]    rd_data
);

  logic [kte_pkg::CHAR_W-1:0]  mem [kte_pkg::MAP_DEPTH];
  logic [kte_pkg::MAP_DEPTH-1:0] written;
  logic [kte_pkg::CHAR_W-1:0]  mem_q;
  logic [kte_pkg::CHAR_W-1:0]  dflt_q;
  logic                        written_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q  <= mem[req.rd_addr];
      dflt_q <= kte_pkg::map_reset_value(req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        written_q <= written[req.rd_addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : dflt_q;

endmodule
